// ----- rtl/rdpp_pkg.sv -----
// rdpp_pkg: shared types, codes and per-section tables for the remote-drive packet parser
// used by rdpp_front, rdpp_queue, rdpp_back and remote_drive_packet_parser
`default_nettype none

package rdpp_pkg;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);
    localparam logic [QCNT_W-1:0] QDEPTH_CNT = QDEPTH[QCNT_W-1:0];
    localparam logic [QPTR_W-1:0] QPTR_LAST = QPTR_W'(QDEPTH - 1);
    localparam logic [QPTR_W-1:0] QPTR_ONE = QPTR_W'(1);
    localparam logic [QCNT_W-1:0] QCNT_ONE = QCNT_W'(1);

    localparam int SEC_BYTES = 16;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_SHORT   = 3'd1;
    localparam logic [2:0] ST_VERSION = 3'd2;
    localparam logic [2:0] ST_BAD_ID  = 3'd3;
    localparam logic [2:0] ST_BAD_LEN = 3'd4;

    localparam logic [2:0] NUM_SECTIONS = 3'd4;

    localparam logic [1:0] SEC_HEADER = 2'd0;
    localparam logic [1:0] SEC_DRIVE  = 2'd1;
    localparam logic [1:0] SEC_STEER  = 2'd2;
    localparam logic [1:0] SEC_LAMP   = 2'd3;

    localparam logic [4:0] FID_HEADER = 5'd0;
    localparam logic [4:0] FID_DRIVE  = 5'd3;
    localparam logic [4:0] FID_STEER  = 5'd13;
    localparam logic [4:0] FID_LAMP   = 5'd19;
    localparam logic [4:0] FID_TURN   = 5'd27;

    typedef logic [7:0] byte_t;

    typedef struct packed {
        logic                        commit;
        logic [1:0]                  sec;
        byte_t [SEC_BYTES-1:0]       bytes;
        logic                        eod;
        logic [2:0]                  status;
    } job_t;

    function automatic logic [3:0] sec_last_idx(input logic [1:0] sec);
        logic [3:0] r;
        unique case (sec)
            SEC_HEADER: r = 4'd7;
            SEC_DRIVE:  r = 4'd15;
            SEC_STEER:  r = 4'd10;
            SEC_LAMP:   r = 4'd10;
            default:    r = 4'd0;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] sec_msg_id(input logic [1:0] sec);
        logic [7:0] r;
        unique case (sec)
            SEC_DRIVE: r = 8'd14;
            SEC_STEER: r = 8'd15;
            SEC_LAMP:  r = 8'd16;
            default:   r = 8'd0;
        endcase
        return r;
    endfunction

    function automatic logic [15:0] sec_msg_len(input logic [1:0] sec);
        logic [15:0] r;
        unique case (sec)
            SEC_DRIVE: r = 16'd13;
            SEC_STEER: r = 16'd8;
            SEC_LAMP:  r = 16'd8;
            default:   r = 16'd0;
        endcase
        return r;
    endfunction

    function automatic logic [3:0] sec_field_count(input logic [1:0] sec);
        logic [3:0] r;
        unique case (sec)
            SEC_HEADER: r = 4'd3;
            SEC_DRIVE:  r = 4'd10;
            SEC_STEER:  r = 4'd6;
            SEC_LAMP:   r = 4'd9;
            default:    r = 4'd0;
        endcase
        return r;
    endfunction

    function automatic logic [4:0] sec_field_base(input logic [1:0] sec);
        logic [4:0] r;
        unique case (sec)
            SEC_HEADER: r = FID_HEADER;
            SEC_DRIVE:  r = FID_DRIVE;
            SEC_STEER:  r = FID_STEER;
            SEC_LAMP:   r = FID_LAMP;
            default:    r = FID_HEADER;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/rdpp_front.sv -----
// rdpp_front: byte intake, section buffering, header checks and job generation
// depends on rdpp_pkg
`default_nettype none

module rdpp_front (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [7:0]        s_tdata,     // [7:0] data_byte
    input  wire logic              s_tlast,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [7:0]        cfg_data,
    input  wire logic              q_full_i,
    output logic                   push_o,
    output rdpp_pkg::job_t         job_o
);

    logic [3:0]  idx_reg, idx_next;
    logic [2:0]  done_reg, done_next;
    logic [2:0]  err_reg, err_next;
    logic [7:0]  version_reg;
    rdpp_pkg::byte_t [rdpp_pkg::SEC_BYTES-1:0] buf_reg;
    rdpp_pkg::byte_t [rdpp_pkg::SEC_BYTES-1:0] view;

    logic        accept;
    logic        active;
    logic [1:0]  sec;
    logic        sec_end;
    logic        sec_ok;
    logic [2:0]  err_sec;
    logic [2:0]  post_err;
    logic [2:0]  post_done;
    logic [2:0]  status;

    assign s_tready  = !q_full_i;
    assign cfg_ready = 1'b1;
    assign accept    = s_tvalid && s_tready;
    assign sec       = done_reg[1:0];
    assign active    = (err_reg == rdpp_pkg::ST_OK) && (done_reg < rdpp_pkg::NUM_SECTIONS);

    // buffer contents including the byte now on the bus
    always_comb begin
        view = buf_reg;
        view[idx_reg] = s_tdata;
    end

    always_comb begin
        err_sec = rdpp_pkg::ST_OK;
        if (sec == rdpp_pkg::SEC_HEADER) begin
            if (view[0] != version_reg) err_sec = rdpp_pkg::ST_VERSION;
        end else if (view[0] != rdpp_pkg::sec_msg_id(sec)) begin
            err_sec = rdpp_pkg::ST_BAD_ID;
        end else if ({view[1], view[2]} != rdpp_pkg::sec_msg_len(sec)) begin
            err_sec = rdpp_pkg::ST_BAD_LEN;
        end
    end

    assign sec_end   = active && (idx_reg == rdpp_pkg::sec_last_idx(sec));
    assign sec_ok    = sec_end && (err_sec == rdpp_pkg::ST_OK);
    assign post_err  = (sec_end && !sec_ok) ? err_sec : err_reg;
    assign post_done = sec_ok ? done_reg + 3'd1 : done_reg;

    always_comb begin
        if (post_err != rdpp_pkg::ST_OK) begin
            status = post_err;
        end else if (post_done < rdpp_pkg::NUM_SECTIONS) begin
            status = rdpp_pkg::ST_SHORT;
        end else begin
            status = rdpp_pkg::ST_OK;
        end
    end

    always_comb begin
        idx_next  = idx_reg;
        done_next = done_reg;
        err_next  = err_reg;
        if (accept) begin
            if (active) begin
                idx_next = sec_end ? 4'd0 : idx_reg + 4'd1;
            end
            if (sec_end) begin
                done_next = post_done;
                err_next  = post_err;
            end
            if (s_tlast) begin
                idx_next  = 4'd0;
                done_next = 3'd0;
                err_next  = rdpp_pkg::ST_OK;
            end
        end
    end

    assign push_o        = accept && (sec_ok || s_tlast);
    assign job_o.commit  = sec_ok;
    assign job_o.sec     = sec;
    assign job_o.bytes   = view;
    assign job_o.eod     = s_tlast;
    assign job_o.status  = status;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg     <= 4'd0;
            done_reg    <= 3'd0;
            err_reg     <= rdpp_pkg::ST_OK;
            version_reg <= 8'd1;
        end else begin
            idx_reg  <= idx_next;
            done_reg <= done_next;
            err_reg  <= err_next;
            if (cfg_valid && cfg_ready) begin
                version_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && active) begin
            buf_reg[idx_reg] <= s_tdata;
        end
    end

    // end of datagram restarts the parse
    a_eod_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_tlast) |=> (idx_reg == 4'd0 && done_reg == 3'd0
                                 && err_reg == rdpp_pkg::ST_OK))
        else $error("parse state not cleared after end of datagram");

endmodule

`default_nettype wire

// ----- rtl/rdpp_queue.sv -----
// rdpp_queue: short job queue between the front and back parts
// depends on rdpp_pkg
`default_nettype none

module rdpp_queue (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              push_i,
    input  wire rdpp_pkg::job_t    job_i,
    output logic                   full_o,
    input  wire logic              pop_i,
    output logic                   valid_o,
    output rdpp_pkg::job_t         head_o
);

    rdpp_pkg::job_t                  mem_reg [rdpp_pkg::QDEPTH];
    logic [rdpp_pkg::QPTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [rdpp_pkg::QPTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [rdpp_pkg::QCNT_W-1:0]     count_reg, count_next;
    logic                            do_push;
    logic                            do_pop;

    assign full_o  = (count_reg == rdpp_pkg::QDEPTH_CNT);
    assign valid_o = (count_reg != '0);
    assign head_o  = mem_reg[rd_ptr_reg];
    assign do_push = push_i && !full_o;
    assign do_pop  = pop_i && valid_o;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == rdpp_pkg::QPTR_LAST) ? '0
                                                               : wr_ptr_reg + rdpp_pkg::QPTR_ONE;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == rdpp_pkg::QPTR_LAST) ? '0
                                                               : rd_ptr_reg + rdpp_pkg::QPTR_ONE;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + rdpp_pkg::QCNT_ONE;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - rdpp_pkg::QCNT_ONE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= job_i;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push_i |-> !full_o)
        else $error("job pushed into full queue");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= rdpp_pkg::QDEPTH_CNT)
        else $error("queue count out of range");

endmodule

`default_nettype wire

// ----- rtl/rdpp_back.sv -----
// rdpp_back: expands queued jobs into field and status results, one per cycle unless m_tready stalls
// depends on rdpp_pkg
`default_nettype none

module rdpp_back (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              q_valid_i,
    input  wire rdpp_pkg::job_t    head_i,
    output logic                   pop_o,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [31:0]            m_tdata,     // [4:0] field_id, [24:5] field_value,
                                                // [27:25] parse_status, [31:28] zero
    output logic                   m_tuser,     // [0] is_status
    output logic                   m_tlast
);

    localparam logic [19:0] PCT_MAX      = 20'd100;
    localparam logic [7:0]  GEAR_MAX     = 8'd3;
    localparam logic [19:0] GEAR_UNKNOWN = 20'd4;
    // ceil(2^20 / 9), exact for magnitudes up to 2^15
    localparam logic [33:0] RECIP9       = 34'd116509;
    localparam logic [18:0] ANGLE_WHOLE  = 19'd11;

    logic [3:0]   cnt_reg, cnt_next;
    logic         m_tvalid_reg, m_tvalid_next;
    logic [31:0]  m_tdata_reg, m_tdata_next;
    logic         m_tuser_reg, m_tuser_next;
    logic         m_tlast_reg, m_tlast_next;

    logic [3:0]   nfields;
    logic         is_field;
    logic         job_last;
    logic [4:0]   fid;
    logic         adv;
    logic         take;
    logic [19:0]  val;

    rdpp_pkg::byte_t [rdpp_pkg::SEC_BYTES-1:0] b;
    logic [15:0]  raw;
    logic [16:0]  raw_ext;
    logic [16:0]  mag;
    logic [33:0]  prod;
    logic [18:0]  amag;
    logic [19:0]  angle;

    function automatic logic [19:0] zx8(input logic [7:0] x);
        return {12'd0, x};
    endfunction

    function automatic logic [19:0] be16(input logic [7:0] hi, input logic [7:0] lo);
        return {4'd0, hi, lo};
    endfunction

    function automatic logic [19:0] clamp_pct(input logic [19:0] x);
        return (x > PCT_MAX) ? PCT_MAX : x;
    endfunction

    function automatic logic [19:0] flag(input logic [7:0] x);
        return (x != 8'd0) ? 20'd1 : 20'd0;
    endfunction

    assign b        = head_i.bytes;
    assign nfields  = rdpp_pkg::sec_field_count(head_i.sec);
    assign is_field = head_i.commit && (cnt_reg < nfields);
    assign fid      = rdpp_pkg::sec_field_base(head_i.sec) + {1'b0, cnt_reg};
    assign job_last = is_field ? ((cnt_reg == nfields - 4'd1) && !head_i.eod) : 1'b1;

    // steer angle: raw*100/9 toward zero = sign * (11*|raw| + |raw|/9)
    assign raw     = {b[3], b[4]};
    assign raw_ext = {raw[15], raw};
    assign mag     = raw[15] ? (17'd0 - raw_ext) : raw_ext;
    assign prod    = {17'd0, mag} * RECIP9;
    assign amag    = {2'd0, mag} * ANGLE_WHOLE + {5'd0, prod[33:20]};
    assign angle   = raw[15] ? (20'd0 - {1'b0, amag}) : {1'b0, amag};

    always_comb begin
        val = 20'd0;
        unique case (fid)
            rdpp_pkg::FID_HEADER:           val = zx8(b[1]);
            rdpp_pkg::FID_HEADER + 5'd1:    val = zx8(b[2]);
            rdpp_pkg::FID_HEADER + 5'd2:    val = zx8(b[3]);
            rdpp_pkg::FID_DRIVE:            val = zx8(b[3]);
            rdpp_pkg::FID_DRIVE + 5'd1:     val = (b[4] <= GEAR_MAX) ? zx8(b[4]) : GEAR_UNKNOWN;
            rdpp_pkg::FID_DRIVE + 5'd2:     val = clamp_pct(be16(b[5], b[6]));
            rdpp_pkg::FID_DRIVE + 5'd3:     val = be16(b[7], b[8]);
            rdpp_pkg::FID_DRIVE + 5'd4:     val = zx8(b[9]);
            rdpp_pkg::FID_DRIVE + 5'd5:     val = zx8(b[10]);
            rdpp_pkg::FID_DRIVE + 5'd6:     val = clamp_pct(be16(b[11], b[12]));
            rdpp_pkg::FID_DRIVE + 5'd7:     val = zx8(b[13]);
            rdpp_pkg::FID_DRIVE + 5'd8:     val = zx8(b[14]);
            rdpp_pkg::FID_DRIVE + 5'd9:     val = zx8(b[15]);
            rdpp_pkg::FID_STEER:            val = angle;
            rdpp_pkg::FID_STEER + 5'd1:     val = zx8(b[5]);
            rdpp_pkg::FID_STEER + 5'd2:     val = zx8(b[6]);
            rdpp_pkg::FID_STEER + 5'd3:     val = zx8(b[7]);
            rdpp_pkg::FID_STEER + 5'd4:     val = zx8(b[8]);
            rdpp_pkg::FID_STEER + 5'd5:     val = be16(b[9], b[10]);
            rdpp_pkg::FID_LAMP:             val = flag(b[3]);
            rdpp_pkg::FID_LAMP + 5'd1:      val = flag(b[4]);
            rdpp_pkg::FID_LAMP + 5'd2:      val = flag(b[5]);
            rdpp_pkg::FID_LAMP + 5'd3:      val = flag(b[6]);
            rdpp_pkg::FID_LAMP + 5'd4:      val = flag(b[7]);
            rdpp_pkg::FID_LAMP + 5'd5:      val = flag(b[8]);
            rdpp_pkg::FID_LAMP + 5'd6:      val = flag(b[9]);
            rdpp_pkg::FID_LAMP + 5'd7:      val = flag(b[10]);
            rdpp_pkg::FID_TURN:             val = (b[4] != 8'd0) ? 20'd1 :
                                                  ((b[5] != 8'd0) ? 20'd2 : 20'd0);
            default:                        val = 20'd0;
        endcase
    end

    assign adv   = !m_tvalid_reg || m_tready;
    assign take  = adv && q_valid_i;
    assign pop_o = take && job_last;

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        m_tlast_next  = m_tlast_reg;
        cnt_next      = cnt_reg;
        if (adv) begin
            m_tvalid_next = q_valid_i;
        end
        if (take) begin
            m_tlast_next = job_last;
            cnt_next     = job_last ? 4'd0 : cnt_reg + 4'd1;
            if (is_field) begin
                m_tuser_next = 1'b0;
                m_tdata_next = {4'd0, rdpp_pkg::ST_OK, val, fid};
            end else begin
                m_tuser_next = 1'b1;
                m_tdata_next = {4'd0, head_i.status, 20'd0, 5'd0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
            cnt_reg      <= 4'd0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
            cnt_reg      <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
        m_tlast_reg <= m_tlast_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    a_status_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && m_tuser_reg) |-> m_tlast_reg)
        else $error("status result not marked last");

    a_cnt_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        (take && !job_last) |=> (cnt_reg != 4'd0))
        else $error("field counter lost its place");

endmodule

`default_nettype wire

// ----- rtl/remote_drive_packet_parser.sv -----
// remote_drive_packet_parser: top level of the remote-drive datagram parser
// depends on rdpp_pkg, rdpp_front, rdpp_queue, rdpp_back
//
// Usage:
//   s_ channel: one datagram byte per beat in s_tdata[7:0], s_tlast on the final byte.
//   m_ channel: one decoded field or status per beat; m_tuser high marks the status,
//     m_tlast marks the last result caused by one input byte.
//   cfg_ channel: writes the expected protocol version byte (reset value 1); always ready.
// Throughput: one byte per cycle while the job queue is not full. A byte that completes
//   a valid section, or ends the datagram, queues a job; the back part emits one result
//   per cycle from the head job unless m_tready stalls, so a drive section gives 10 results,
//   steer 6, lamp 9, header 3, plus 1 for a status. A taken byte's job is written into the
//   job queue, then its first result is loaded from the queue head into the output register.
// s_tready drops only while the 4-entry job queue is full; a stall on m_tready holds
//   the output register and backs up into the queue.
// Reset (aresetn low, synchronous) empties the queue, clears the output valid and the
//   parse position, and restores the protocol version to 1.
`default_nettype none

module remote_drive_packet_parser (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [7:0]   s_tdata,     // [7:0] data_byte
    input  wire logic         s_tlast,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [31:0]       m_tdata,     // [4:0] field_id, [24:5] field_value,
                                           // [27:25] parse_status, [31:28] zero
    output logic              m_tuser,     // [0] is_status
    output logic              m_tlast,
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [7:0]   cfg_data
);

    logic            push;
    logic            q_full;
    logic            q_valid;
    logic            pop;
    rdpp_pkg::job_t  job;
    rdpp_pkg::job_t  head;

    rdpp_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .q_full_i  (q_full),
        .push_o    (push),
        .job_o     (job)
    );

    rdpp_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push_i  (push),
        .job_i   (job),
        .full_o  (q_full),
        .pop_i   (pop),
        .valid_o (q_valid),
        .head_o  (head)
    );

    rdpp_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid_i (q_valid),
        .head_i    (head),
        .pop_o     (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

`default_nettype wire
